// ----- hdl/pauli_basis_su2_arith_unit_top_assert.svh -----
// Assertion macros for the Pauli-basis arithmetic unit
`ifndef PAULI_BASIS_SU2_ARITH_UNIT_TOP_ASSERT_SVH
`define PAULI_BASIS_SU2_ARITH_UNIT_TOP_ASSERT_SVH

// same-cycle implication
`define PBSU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PBSU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/pbsu_pkg.sv -----
package pbsu_pkg;

	localparam int PBSU_COEF_WIDTH = 32;
	localparam int PBSU_FRAC_BITS  = 30;

	// operation codes
	localparam logic [1:0] MODE_MUL  = 2'd0;
	localparam logic [1:0] MODE_DOT  = 2'd1;
	localparam logic [1:0] MODE_DIST = 2'd2;
	localparam logic [1:0] MODE_INV  = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	// control that travels beside the data
	typedef struct packed {
		logic       vld;
		logic [1:0] mode;
		logic       zero;
		logic       sat;
	} pbsu_ctl_t;

endpackage

// ----- hdl/pbsu_delay.sv -----
module pbsu_delay #(
	parameter int WD    = 8,
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [WD-1:0] din,
	output logic [WD-1:0] dout
);

	logic [WD-1:0] dly_q [DEPTH];

	// plain shift line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) dly_q[i] <= '0;
		end else begin
			dly_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) dly_q[i] <= dly_q[i-1];
		end
	end

	assign dout = dly_q[DEPTH-1];

endmodule

// ----- hdl/pbsu_front.sv -----
module pbsu_front import pbsu_pkg::*; #(
	parameter int COEF_WIDTH = PBSU_COEF_WIDTH,
	parameter int FRAC_BITS  = PBSU_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [1:0]                   mode,
	input  logic signed [COEF_WIDTH-1:0] a [4],
	input  logic signed [COEF_WIDTH-1:0] b [4],
	output pbsu_ctl_t                    ctl_s3,
	output logic signed [COEF_WIDTH-1:0] r_s3 [4],
	output logic [2*COEF_WIDTH+1:0]      dabs_s3,
	output logic [COEF_WIDTH-1:0]        mag_s3 [4],
	output logic [3:0]                   neg_s3
);

	localparam int W  = COEF_WIDTH;
	localparam int PW = 2*W;
	localparam int TW = 2*W+2;
	localparam logic signed [TW-1:0] HALF = TW'(1) << (FRAC_BITS-1);
	localparam logic signed [TW-1:0] MAXV = (TW'(1) << (W-1)) - TW'(1);
	localparam logic signed [TW-1:0] MINV = ~MAXV;

	logic signed [W-1:0]  bm [4];
	logic                 vld_s1, vld_s2;
	logic [1:0]           mode_s1, mode_s2;
	logic signed [PW-1:0] p_s1 [4][4];
	logic signed [W-1:0]  a_s1 [4];
	logic signed [TW-1:0] t_s2 [4];
	logic signed [TW-1:0] d_s2;
	logic [W-1:0]         mag_s2 [4];
	logic [3:0]           neg_s2;
	logic signed [W-1:0]  rt [4];
	logic [3:0]           sat_t;
	logic [TW-1:0]        dabs;
	logic signed [W-1:0]  rd;
	logic                 sat_d;

	function automatic logic signed [TW-1:0] ext(input logic signed [PW-1:0] x);
		return TW'(x);
	endfunction

	// round half up from 2F to F fraction bits, clamp; returns {sat, value}
	function automatic logic [W:0] rnd_sat(input logic signed [TW-1:0] v);
		logic signed [TW-1:0] sh;
		sh = (v + HALF) >>> FRAC_BITS;
		if (sh > MAXV) return {1'b1, MAXV[W-1:0]};
		else if (sh < MINV) return {1'b1, MINV[W-1:0]};
		else return {1'b0, sh[W-1:0]};
	endfunction

	// inverse mode squares A: diagonal products give the norm
	always_comb begin
		for (int j = 0; j < 4; j++) bm[j] = (mode == MODE_INV) ? a[j] : b[j];
	end

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			ctl_s3 <= '0;
		end else begin
			vld_s1      <= start;
			vld_s2      <= vld_s1;
			ctl_s3.vld  <= vld_s2;
			ctl_s3.mode <= mode_s2;
			ctl_s3.zero <= (d_s2 == '0);
			ctl_s3.sat  <= (mode_s2 == MODE_DOT) ? sat_d : |sat_t;
		end
	end

	// stage 1: all sixteen cross products
	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		for (int i = 0; i < 4; i++) begin
			a_s1[i] <= a[i];
			for (int j = 0; j < 4; j++) p_s1[i][j] <= PW'(a[i]) * PW'(bm[j]);
		end
	end

	// stage 2: exact component sums, dot product, operand magnitudes
	always_ff @(posedge clk) begin
		mode_s2 <= mode_s1;
		t_s2[0] <= ext(p_s1[0][0]) - ext(p_s1[1][1]) - ext(p_s1[2][2]) - ext(p_s1[3][3]);
		t_s2[1] <= ext(p_s1[3][2]) + ext(p_s1[0][1]) + ext(p_s1[1][0]) - ext(p_s1[2][3]);
		t_s2[2] <= ext(p_s1[0][2]) - ext(p_s1[3][1]) + ext(p_s1[2][0]) + ext(p_s1[1][3]);
		t_s2[3] <= ext(p_s1[3][0]) + ext(p_s1[0][3]) - ext(p_s1[1][2]) + ext(p_s1[2][1]);
		d_s2    <= ext(p_s1[0][0]) + ext(p_s1[1][1]) + ext(p_s1[2][2]) + ext(p_s1[3][3]);
		for (int i = 0; i < 4; i++) begin
			mag_s2[i] <= a_s1[i][W-1] ? unsigned'(-a_s1[i]) : unsigned'(a_s1[i]);
			neg_s2[i] <= ((i == 0) ? a_s1[i][W-1] : !a_s1[i][W-1]) && (a_s1[i] != '0);
		end
	end

	// stage 3 logic: rounding and absolute dot
	always_comb begin
		for (int i = 0; i < 4; i++) {sat_t[i], rt[i]} = rnd_sat(t_s2[i]);
		dabs = d_s2[TW-1] ? unsigned'(-d_s2) : unsigned'(d_s2);
		{sat_d, rd} = rnd_sat(signed'(dabs));
	end

	always_ff @(posedge clk) begin
		r_s3[0] <= (mode_s2 == MODE_DOT) ? rd : rt[0];
		for (int i = 1; i < 4; i++) r_s3[i] <= rt[i];
		dabs_s3 <= dabs;
		for (int i = 0; i < 4; i++) mag_s3[i] <= mag_s2[i];
		neg_s3 <= neg_s2;
	end

endmodule

// ----- hdl/pbsu_sqrt.sv -----
module pbsu_sqrt import pbsu_pkg::*; #(
	parameter int COEF_WIDTH = PBSU_COEF_WIDTH,
	parameter int FRAC_BITS  = PBSU_FRAC_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [2*COEF_WIDTH+1:0] dabs,
	output logic [COEF_WIDTH-1:0]   root
);

	localparam int W   = COEF_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int TW  = 2*W+2;
	localparam int RW  = 2*F+1;
	localparam int SW  = F+1;
	localparam int XW  = 2*F+3;
	localparam int PAD = W-F;
	localparam logic [TW:0] ONE2F = (TW+1)'(1) << (2*F);

	logic signed [TW:0] diff;
	logic               go;
	logic [RW-1:0]      rem_s  [F+2];
	logic [SW-1:0]      root_s [F+2];
	logic [W-1:0]       res_q;

	// 1 - |dot|; nonpositive gives a zero root
	always_comb begin
		diff = signed'(ONE2F) - signed'({1'b0, dabs});
		go   = !diff[TW] && (diff != '0);
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= go ? diff[RW-1:0] : '0;
		root_s[0] <= '0;
	end

	// one root bit per stage, remainder kept as diff - root^2
	for (genvar j = 0; j <= F; j++) begin : g_step
		localparam int K = F-j;
		logic [XW-1:0] trial;
		logic          take;
		always_comb begin
			trial = (XW'(root_s[j]) << (K+1)) | (XW'(1) << (2*K));
			take  = trial <= XW'(rem_s[j]);
		end
		always_ff @(posedge clk) begin
			rem_s[j+1]  <= take ? rem_s[j] - trial[RW-1:0] : rem_s[j];
			root_s[j+1] <= take ? (root_s[j] | (SW'(1) << K)) : root_s[j];
		end
	end

	// round to nearest
	always_ff @(posedge clk) begin
		res_q <= (rem_s[F+1] > RW'(root_s[F+1])) ? W'(root_s[F+1]) + W'(1)
			: W'(root_s[F+1]);
	end

	// align with the divider latency
	pbsu_delay #(.WD(W), .DEPTH(PAD)) u_pad (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (res_q),
		.dout   (root)
	);

endmodule

// ----- hdl/pbsu_div.sv -----
module pbsu_div import pbsu_pkg::*; #(
	parameter int COEF_WIDTH = PBSU_COEF_WIDTH,
	parameter int FRAC_BITS  = PBSU_FRAC_BITS
) (
	input  logic                         clk,
	input  logic [COEF_WIDTH-1:0]        mag,
	input  logic                         neg,
	input  logic [2*COEF_WIDTH+1:0]      n,
	output logic signed [COEF_WIDTH-1:0] quo,
	output logic                         sat
);

	localparam int W  = COEF_WIDTH;
	localparam int TW = 2*W+2;
	localparam int QB = W+1;
	localparam int RW = TW+QB;
	localparam logic [QB:0] LIM  = (QB+1)'(1) << (W-1);
	localparam logic [QB:0] MAXM = LIM - (QB+1)'(1);
	localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

	logic [RW-1:0]   xin;
	logic [RW-1:0]   rem_s [QB+1];
	logic [QB-1:0]   q_s   [QB+1];
	logic [TW-1:0]   n_s   [QB+1];
	logic [QB:0]     neg_s, ovf_s;
	logic            rup;
	logic [QB:0]     qr;
	logic signed [W-1:0] v;
	logic            sat_n;

	// dividend mag * 2^2F; a quotient of QB bits or more always clamps
	assign xin = RW'(mag) << (2*FRAC_BITS);

	always_ff @(posedge clk) begin
		rem_s[0] <= xin;
		q_s[0]   <= '0;
		n_s[0]   <= n;
		neg_s[0] <= neg;
		ovf_s[0] <= xin >= (RW'(n) << QB);
	end

	// restoring divide, one quotient bit per stage
	for (genvar j = 0; j < QB; j++) begin : g_step
		localparam int K = QB-1-j;
		logic [RW-1:0] shv;
		logic          take;
		always_comb begin
			shv  = RW'(n_s[j]) << K;
			take = rem_s[j] >= shv;
		end
		always_ff @(posedge clk) begin
			rem_s[j+1] <= take ? rem_s[j] - shv : rem_s[j];
			q_s[j+1]   <= take ? (q_s[j] | (QB'(1) << K)) : q_s[j];
			n_s[j+1]   <= n_s[j];
			neg_s[j+1] <= neg_s[j];
			ovf_s[j+1] <= ovf_s[j];
		end
	end

	// round half up in magnitude, apply sign, clamp
	always_comb begin
		rup   = ((RW+1)'(rem_s[QB]) << 1) >= (RW+1)'(n_s[QB]);
		qr    = (QB+1)'(q_s[QB]) + (QB+1)'(rup);
		sat_n = 1'b1;
		if (ovf_s[QB]) v = neg_s[QB] ? VMIN : VMAX;
		else if (!neg_s[QB] && qr > MAXM) v = VMAX;
		else if (neg_s[QB] && qr > LIM) v = VMIN;
		else begin
			sat_n = 1'b0;
			v     = neg_s[QB] ? -signed'(qr[W-1:0]) : signed'(qr[W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		quo <= v;
		sat <= sat_n;
	end

endmodule

// ----- hdl/pauli_basis_su2_arith_unit_top.sv -----
// start reaches done through the front stages, the align delay and the done register.
// Throughput: one word per cycle; busy stays low, start is taken every cycle.
// The latency is set by the restoring divider, one quotient bit per stage.
// Reset (arst_n low, asynchronous) clears every valid bit; words in flight are dropped.
// The receiver cannot stall: each result shows for one cycle with done high.
`include "pauli_basis_su2_arith_unit_top_assert.svh"

module pauli_basis_su2_arith_unit_top import pbsu_pkg::*; #(
	parameter int COEF_WIDTH = PBSU_COEF_WIDTH,
	parameter int FRAC_BITS  = PBSU_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   mode,
	input  logic signed [COEF_WIDTH-1:0] a_c0,
	input  logic signed [COEF_WIDTH-1:0] a_c1,
	input  logic signed [COEF_WIDTH-1:0] a_c2,
	input  logic signed [COEF_WIDTH-1:0] a_c3,
	input  logic signed [COEF_WIDTH-1:0] b_c0,
	input  logic signed [COEF_WIDTH-1:0] b_c1,
	input  logic signed [COEF_WIDTH-1:0] b_c2,
	input  logic signed [COEF_WIDTH-1:0] b_c3,
	output logic                         done,
	output logic signed [COEF_WIDTH-1:0] r_c0,
	output logic signed [COEF_WIDTH-1:0] r_c1,
	output logic signed [COEF_WIDTH-1:0] r_c2,
	output logic signed [COEF_WIDTH-1:0] r_c3,
	output logic [1:0]                   status
);

	localparam int W   = COEF_WIDTH;
	localparam int TW  = 2*W+2;
	localparam int DLY = W+3;
	localparam int LAT = W+7;
	localparam int CW  = $bits(pbsu_ctl_t);
	localparam int DW  = CW + 4*W;

	logic signed [W-1:0] a_in [4];
	logic signed [W-1:0] b_in [4];
	pbsu_ctl_t           ctl_s3, ctl_d;
	logic signed [W-1:0] r_s3 [4];
	logic [TW-1:0]       dabs_s3;
	logic [W-1:0]        mag_s3 [4];
	logic [3:0]          neg_s3;
	logic signed [W-1:0] dq [4];
	logic [3:0]          dsat;
	logic [W-1:0]        sq;
	logic [DW-1:0]       bun_in, bun_out;
	logic signed [W-1:0] rq [4];
	logic signed [W-1:0] rn [4];
	logic [1:0]          st;

	assign busy = 1'b0;

	assign a_in[0] = a_c0;
	assign a_in[1] = a_c1;
	assign a_in[2] = a_c2;
	assign a_in[3] = a_c3;
	assign b_in[0] = b_c0;
	assign b_in[1] = b_c1;
	assign b_in[2] = b_c2;
	assign b_in[3] = b_c3;

	// products, sums, rounding
	pbsu_front #(.COEF_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.mode    (mode),
		.a       (a_in),
		.b       (b_in),
		.ctl_s3  (ctl_s3),
		.r_s3    (r_s3),
		.dabs_s3 (dabs_s3),
		.mag_s3  (mag_s3),
		.neg_s3  (neg_s3)
	);

	// one divider lane per coefficient of the inverse
	for (genvar g = 0; g < 4; g++) begin : g_div
		pbsu_div #(.COEF_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
			.clk (clk),
			.mag (mag_s3[g]),
			.neg (neg_s3[g]),
			.n   (dabs_s3),
			.quo (dq[g]),
			.sat (dsat[g])
		);
	end

	pbsu_sqrt #(.COEF_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.dabs   (dabs_s3),
		.root   (sq)
	);

	// control and early results wait for the divider
	assign bun_in = {ctl_s3, r_s3[3], r_s3[2], r_s3[1], r_s3[0]};

	pbsu_delay #(.WD(DW), .DEPTH(DLY)) u_align (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (bun_in),
		.dout   (bun_out)
	);

	assign ctl_d = pbsu_ctl_t'(bun_out[DW-1 -: CW]);

	// result select
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			rq[i] = bun_out[i*W +: W];
			rn[i] = '0;
		end
		st = ST_OK;
		case (ctl_d.mode)
			MODE_MUL: begin
				for (int i = 0; i < 4; i++) rn[i] = rq[i];
				st = ctl_d.sat ? ST_SAT : ST_OK;
			end
			MODE_DOT: begin
				rn[0] = rq[0];
				st    = ctl_d.sat ? ST_SAT : ST_OK;
			end
			MODE_DIST: begin
				rn[0] = signed'(sq);
			end
			MODE_INV: begin
				if (ctl_d.zero) st = ST_ZERO;
				else begin
					for (int i = 0; i < 4; i++) rn[i] = dq[i];
					st = (|dsat) ? ST_SAT : ST_OK;
				end
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= ctl_d.vld;
	end

	always_ff @(posedge clk) begin
		r_c0   <= rn[0];
		r_c1   <= rn[1];
		r_c2   <= rn[2];
		r_c3   <= rn[3];
		status <= st;
	end

	// checks
	`PBSU_ASSERT_IMP(a_done_src, done, $past(start, LAT), "done without a start")
	`PBSU_ASSERT_IMP(a_zero_clr, done && status == ST_ZERO, r_c0 == '0 && r_c1 == '0 && r_c2 == '0 && r_c3 == '0, "zero norm result not cleared")
	`PBSU_ASSERT_NXT(a_zero_mode, ctl_d.vld && ctl_d.mode != MODE_INV, status != ST_ZERO, "zero norm flagged outside inverse")

endmodule
